### design/csv_field_tokenizer_top_macros.svh
// Assertion macros for the CSV field tokenizer checker.
// Used by csvt_checker.sv; no other dependencies.
`ifndef CSV_FIELD_TOKENIZER_TOP_MACROS_SVH
`define CSV_FIELD_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/csvt_pkg.sv
// Shared types and constants of the CSV field tokenizer.
// No dependencies; used by every module of the block.
package csvt_pkg;

    // event kinds of a result
    localparam logic [2:0] EV_DATA    = 3'd0;
    localparam logic [2:0] EV_FIELD   = 3'd1;
    localparam logic [2:0] EV_ROW     = 3'd2;
    localparam logic [2:0] EV_NOFIELD = 3'd3;
    localparam logic [2:0] EV_ERROR   = 3'd4;

    // fixed text bytes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] DELIM_RESET = 8'd44;

    // command queue between front and back; depth must be a power of two
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] data_byte;
        logic       was_quoted;
        logic       spill_flag;
        logic       last_of_run;
    } t_out;

    typedef enum logic [1:0] {
        CMD_HOLD       = 2'd0,  // hold a whitespace byte, spill oldest if full
        CMD_FLUSH_DATA = 2'd1,  // release held run, then the data byte
        CMD_FLUSH_ONLY = 2'd2,  // release held run (closing quote)
        CMD_EMIT       = 2'd3   // drop held run, give one event
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        logic [2:0] kind;
        logic       quoted;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### design/csvt_front.sv
// Front end: accepts input bytes, tracks the parse mode, issues commands.
// Depends on csvt_pkg.
module csvt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csvt_pkg::t_in      i_in_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    input  csvt_pkg::t_q_status i_q_status,
    output logic               o_push,
    output csvt_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        MODE_BEFORE  = 5'b00001,
        MODE_PLAIN   = 5'b00010,
        MODE_QUOTED  = 5'b00100,
        MODE_CLOSED  = 5'b01000,
        MODE_DISCARD = 5'b10000
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [7:0] r_delim;

    logic           w_accept;
    logic           w_push;
    csvt_pkg::t_cmd w_cmd;
    logic [7:0]     w_c;
    logic           w_nl, w_dl, w_qt, w_spt, w_ws;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_status.full;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_c   = i_in_data.byte_value;
    assign w_nl  = (w_c == csvt_pkg::CH_NL);
    assign w_dl  = (w_c == r_delim);
    assign w_qt  = (w_c == csvt_pkg::CH_QUOTE);
    assign w_spt = (w_c == csvt_pkg::CH_SP) || (w_c == csvt_pkg::CH_TAB);
    assign w_ws  = w_spt || (w_c == csvt_pkg::CH_CR);

    always_comb begin
        n_mode       = r_mode;
        w_push       = 1'b0;
        w_cmd.op     = csvt_pkg::CMD_EMIT;
        w_cmd.data   = w_c;
        w_cmd.kind   = w_nl ? csvt_pkg::EV_ROW : csvt_pkg::EV_FIELD;
        w_cmd.quoted = 1'b0;
        if (i_in_data.end_of_input) begin
            w_push = 1'b1;
            n_mode = MODE_BEFORE;
            unique case (r_mode)
                MODE_PLAIN: begin
                    w_cmd.kind = csvt_pkg::EV_ROW;
                end
                MODE_QUOTED, MODE_CLOSED: begin
                    w_cmd.kind   = csvt_pkg::EV_ROW;
                    w_cmd.quoted = 1'b1;
                end
                default: begin
                    w_cmd.kind = csvt_pkg::EV_NOFIELD;
                end
            endcase
        end else begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    w_push = 1'b1;
                    if (w_dl || w_nl) begin
                        n_mode = MODE_BEFORE;
                    end else if (w_ws) begin
                        w_cmd.op = csvt_pkg::CMD_HOLD;
                    end else begin
                        w_cmd.op = csvt_pkg::CMD_FLUSH_DATA;
                    end
                end
                MODE_QUOTED: begin
                    w_push = 1'b1;
                    if (w_qt) begin
                        w_cmd.op = csvt_pkg::CMD_FLUSH_ONLY;
                        n_mode   = MODE_CLOSED;
                    end else if (w_ws) begin
                        w_cmd.op = csvt_pkg::CMD_HOLD;
                    end else begin
                        w_cmd.op = csvt_pkg::CMD_FLUSH_DATA;
                    end
                end
                MODE_CLOSED: begin
                    if (w_dl || w_nl) begin
                        w_push       = 1'b1;
                        w_cmd.quoted = 1'b1;
                        n_mode       = MODE_BEFORE;
                    end else if (!w_ws) begin
                        w_push     = 1'b1;
                        w_cmd.kind = csvt_pkg::EV_ERROR;
                        n_mode     = MODE_DISCARD;
                    end
                end
                MODE_DISCARD: begin
                    if (w_nl) begin
                        n_mode = MODE_BEFORE;
                    end
                end
                default: begin
                    // before a field: skip, then quote, then separators
                    priority if (w_spt) begin
                        n_mode = MODE_BEFORE;
                    end else if (w_qt) begin
                        n_mode = MODE_QUOTED;
                    end else if (w_dl || w_nl) begin
                        w_push = 1'b1;
                        n_mode = MODE_BEFORE;
                    end else begin
                        // lone CR opens a field as held whitespace
                        w_push   = 1'b1;
                        w_cmd.op = w_ws ? csvt_pkg::CMD_HOLD : csvt_pkg::CMD_FLUSH_DATA;
                        n_mode   = MODE_PLAIN;
                    end
                end
            endcase
        end
    end

    assign o_push = w_accept && w_push;
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BEFORE;
            r_delim <= csvt_pkg::DELIM_RESET;
        end else begin
            if (w_accept) begin
                r_mode <= n_mode;
            end
            if (i_cfg_valid) begin
                r_delim <= i_cfg_data;
            end
        end
    end

endmodule

### design/csvt_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on csvt_pkg.
module csvt_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csvt_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output csvt_pkg::t_cmd      o_cmd,
    output csvt_pkg::t_q_status o_status
);

    localparam int CW = csvt_pkg::CMDQ_AW + 1;

    csvt_pkg::t_cmd                r_mem [csvt_pkg::CMDQ_DEPTH];
    logic [csvt_pkg::CMDQ_AW-1:0] r_wp, r_rp;
    logic [CW-1:0]                 r_cnt;

    assign o_status.full  = (r_cnt == CW'(csvt_pkg::CMDQ_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_cmd          = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/csvt_back.sv
// Back end: held-whitespace ring buffer and result sequencer with output register.
// Depends on csvt_pkg.
module csvt_back #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csvt_pkg::t_cmd      i_cmd,
    input  csvt_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csvt_pkg::t_out      o_out_data
);

    localparam int PW = $clog2(HOLD_DEPTH);
    localparam int CW = $clog2(HOLD_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_CMD   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DATA  = 3'b100
    } t_state;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [7:0]     r_hold [HOLD_DEPTH];
    logic [7:0]     r_rd;
    logic           r_ov;
    csvt_pkg::t_out r_out, n_res;

    logic           w_we, w_load, w_free, w_full;
    logic [PW-1:0]  w_tail, w_head_inc;
    logic [CW:0]    w_sum;

    assign w_free = !r_ov || i_out_ready;
    assign w_full = (r_cnt == CW'(HOLD_DEPTH));
    assign w_sum  = {1'b0, CW'(r_head)} + {1'b0, r_cnt};
    assign w_tail = (w_sum >= (CW+1)'(HOLD_DEPTH)) ? PW'(w_sum - (CW+1)'(HOLD_DEPTH))
                                                   : PW'(w_sum);
    assign w_head_inc = (r_head == PW'(HOLD_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_cnt   = r_cnt;
        w_we    = 1'b0;
        w_load  = 1'b0;
        o_pop   = 1'b0;
        n_res.event_kind  = csvt_pkg::EV_DATA;
        n_res.data_byte   = r_rd;
        n_res.was_quoted  = 1'b0;
        n_res.spill_flag  = 1'b0;
        n_res.last_of_run = 1'b1;
        unique case (r_state)
            ST_FLUSH: begin
                if (w_free) begin
                    w_load            = 1'b1;
                    n_res.last_of_run = (r_cnt == CW'(1))
                                        && (i_cmd.op == csvt_pkg::CMD_FLUSH_ONLY);
                    n_head            = w_head_inc;
                    n_cnt             = r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        if (i_cmd.op == csvt_pkg::CMD_FLUSH_DATA) begin
                            n_state = ST_DATA;
                        end else begin
                            o_pop   = 1'b1;
                            n_state = ST_CMD;
                        end
                    end
                end
            end
            ST_DATA: begin
                if (w_free) begin
                    w_load          = 1'b1;
                    n_res.data_byte = i_cmd.data;
                    o_pop           = 1'b1;
                    n_state         = ST_CMD;
                end
            end
            default: begin
                if (!i_q_status.empty) begin
                    unique case (i_cmd.op)
                        csvt_pkg::CMD_HOLD: begin
                            if (!w_full) begin
                                w_we  = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                o_pop = 1'b1;
                            end else if (w_free) begin
                                // oldest byte leaves early; new one takes its slot
                                w_load           = 1'b1;
                                n_res.spill_flag = 1'b1;
                                w_we             = 1'b1;
                                n_head           = w_head_inc;
                                o_pop            = 1'b1;
                            end
                        end
                        csvt_pkg::CMD_FLUSH_DATA: begin
                            if (r_cnt != '0) begin
                                n_state = ST_FLUSH;
                            end else if (w_free) begin
                                w_load          = 1'b1;
                                n_res.data_byte = i_cmd.data;
                                o_pop           = 1'b1;
                            end
                        end
                        csvt_pkg::CMD_FLUSH_ONLY: begin
                            if (r_cnt != '0) begin
                                n_state = ST_FLUSH;
                            end else begin
                                o_pop = 1'b1;
                            end
                        end
                        default: begin
                            if (w_free) begin
                                w_load           = 1'b1;
                                n_res.event_kind = i_cmd.kind;
                                n_res.data_byte  = 8'd0;
                                n_res.was_quoted = i_cmd.quoted;
                                n_cnt            = '0;
                                o_pop            = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // ring buffer, write-first read of the next head entry
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hold[w_tail] <= i_cmd.data;
        end
        if (w_we && (w_tail == n_head)) begin
            r_rd <= i_cmd.data;
        end else begin
            r_rd <= r_hold[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CMD;
            r_head  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

### design/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: front end, command queue, back end.
// Depends on csvt_pkg, csvt_front, csvt_cmd_fifo, csvt_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_in_data  (csvt_pkg::t_in)
//  out     | output    | o_out_valid/i_out_ready| o_out_data (csvt_pkg::t_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (delimiter)
//
// The front end takes one byte per cycle while the 4-entry command queue has room.
// The back end waits while its output is stalled; a command that flushes held bytes
// first enters the flush state, then releases them oldest first, then any data byte.
// Skipped bytes push no command; a closing quote with nothing held gives no result.
// Output stalls back up through the queue to o_in_ready; the config port never stalls.
// Reset is synchronous and active low; there is no clearing pass.
module csv_field_tokenizer_top #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  csvt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output csvt_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);

    logic                w_push, w_pop;
    csvt_pkg::t_cmd      w_cmd_in, w_cmd_out;
    csvt_pkg::t_q_status w_q_status;

    csvt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in)
    );

    csvt_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_out),
        .o_status (w_q_status)
    );

    csvt_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/csvt_checker.sv
// Port-level checker for the CSV field tokenizer, bound to the top level.
// Depends on csvt_pkg and csv_field_tokenizer_top_macros.svh.
`include "csv_field_tokenizer_top_macros.svh"

module csvt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input csvt_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input csvt_pkg::t_out o_out_data,
    input logic           i_cfg_valid,
    input logic           o_cfg_ready,
    input logic [7:0]     i_cfg_data
);

    `CSVT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "output transaction changed while stalled")

    `CSVT_ASSERT_NOW(a_event_clean, o_out_valid && (o_out_data.event_kind != csvt_pkg::EV_DATA), (o_out_data.data_byte == 8'd0) && !o_out_data.spill_flag, "non-data event carries data")

    `CSVT_ASSERT_NOW(a_event_last, o_out_valid && (o_out_data.event_kind != csvt_pkg::EV_DATA), o_out_data.last_of_run, "event is not the last result of its item")

    `CSVT_ASSERT_NOW(a_spill_last, o_out_valid && o_out_data.spill_flag, o_out_data.last_of_run && (o_out_data.event_kind == csvt_pkg::EV_DATA), "spilled byte is not a lone data result")

    `CSVT_ASSERT_NOW(a_quoted_kind, o_out_valid && o_out_data.was_quoted, (o_out_data.event_kind == csvt_pkg::EV_FIELD) || (o_out_data.event_kind == csvt_pkg::EV_ROW), "quoted flag on a non-field-end event")

endmodule

bind csv_field_tokenizer_top csvt_checker u_csvt_checker (.*);
